// File: hw/rtl/etf_pkg.sv
// Shared types, widths and constants for the escape-time fractal pixel block.
// Used by every module under hw/rtl; depends on nothing.
package etf_pkg;

  // Field and arithmetic widths.
  localparam int FRAC_BITS     = 28;
  localparam int INDEX_BITS    = 12;
  localparam int COUNT_BITS    = 16;
  localparam int VAL_BITS      = 32;
  localparam int STEP_BITS     = 31;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 16;

  // Derived widths.
  localparam int PROD_BITS = 2 * VAL_BITS;
  localparam int SQ_BITS   = PROD_BITS - FRAC_BITS;
  localparam int XY_BITS   = PROD_BITS - FRAC_BITS + 1;
  localparam int SUM_BITS  = XY_BITS + 1;
  localparam int PC_BITS   = INDEX_BITS + STEP_BITS;
  localparam int C_BITS    = PC_BITS + 2;
  localparam int SAT_BITS  = (C_BITS > SUM_BITS) ? C_BITS : SUM_BITS;

  // Escape limit 4.0 in the sum's format.
  localparam logic signed [SUM_BITS-1:0] LIMIT = SUM_BITS'(4) << FRAC_BITS;
  localparam logic signed [SAT_BITS-1:0] SAT_HI = SAT_BITS'(2**(VAL_BITS-1) - 1);
  localparam logic signed [SAT_BITS-1:0] SAT_LO = -SAT_HI - SAT_BITS'(1);

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER = 3'd4;

  // Register reset values: -2.0, -2.0, 1/256, 1/256, 2048 rounds.
  localparam logic signed [VAL_BITS-1:0] X_MIN_RST    = -32'sd536870912;
  localparam logic signed [VAL_BITS-1:0] Y_MIN_RST    = -32'sd536870912;
  localparam logic [STEP_BITS-1:0]       X_STEP_RST   = 31'd1048576;
  localparam logic [STEP_BITS-1:0]       Y_STEP_RST   = 31'd1048576;
  localparam logic [COUNT_BITS-1:0]      MAX_ITER_RST = 16'd2048;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] x_min;
    logic signed [VAL_BITS-1:0] y_min;
    logic [STEP_BITS-1:0]       x_step;
    logic [STEP_BITS-1:0]       y_step;
    logic [COUNT_BITS-1:0]      max_iterations;
  } etf_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the pixel and form the step products
    logic calc_c;    // form c and start z = c, round zero
    logic mul;       // register the two squares and the cross product
    logic step;      // z = z*z + c, next round
    logic res_load;  // capture the result
    logic res_hit;   // result is the round count, otherwise zero
    logic out_load;  // move the result into the output register
  } etf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escape;      // |z|^2 > 4 for the current products
    logic last_round;  // the current round is the last one allowed
    logic max_zero;    // no rounds allowed at all
  } etf_status_t;

  // Clamp to the signed value range.
  function automatic logic signed [VAL_BITS-1:0] sat_val(
    input logic signed [SAT_BITS-1:0] v
  );
    logic signed [VAL_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VAL_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VAL_BITS-1:0];
    end else begin
      r = v[VAL_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/etf_cfg_regs.sv
// Configuration register file of the escape-time fractal pixel block.
// Depends on etf_pkg.
module etf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [etf_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
  input  logic [etf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output etf_pkg::etf_cfg_t                   cfg
);
  import etf_pkg::*;

  etf_cfg_t cfg_r;
  etf_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_X_MIN:    cfg_nxt.x_min          = $signed(cfg_wdata[VAL_BITS-1:0]);
        REG_Y_MIN:    cfg_nxt.y_min          = $signed(cfg_wdata[VAL_BITS-1:0]);
        REG_X_STEP:   cfg_nxt.x_step         = cfg_wdata[STEP_BITS-1:0];
        REG_Y_STEP:   cfg_nxt.y_step         = cfg_wdata[STEP_BITS-1:0];
        REG_MAX_ITER: cfg_nxt.max_iterations = cfg_wdata[COUNT_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min          <= X_MIN_RST;
      cfg_r.y_min          <= Y_MIN_RST;
      cfg_r.x_step         <= X_STEP_RST;
      cfg_r.y_step         <= Y_STEP_RST;
      cfg_r.max_iterations <= MAX_ITER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/etf_ctrl.sv
// Controller state machine of the escape-time fractal pixel block.
// Depends on etf_pkg; drives the datapath by commands only.
module etf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  etf_pkg::etf_status_t status,
  output etf_pkg::etf_cmd_t    cmd
);
  import etf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_TEST  = 5'b01000,
    ST_DONE  = 5'b10000
  } etf_state_t;

  etf_state_t state_r;
  etf_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.calc_c = 1'b1;
        if (status.max_zero) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (status.escape) begin
          cmd.res_load = 1'b1;
          cmd.res_hit  = 1'b1;
          state_nxt    = ST_DONE;
        end else if (status.last_round) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");
  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SETUP))
    else $error("accepted pixel did not start setup");
  a_res_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> (state_r == ST_DONE && !in_tready))
    else $error("result captured without waiting for output slot");
  a_round_loop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (state_r == ST_TEST && !status.escape && !status.last_round))
    else $error("round advanced past escape or last round");
`endif

endmodule

// File: hw/rtl/etf_datapath.sv
// Fixed-point datapath of the escape-time fractal pixel block: c setup,
// squaring multipliers, update with saturation, round counter. Depends on etf_pkg.
module etf_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [etf_pkg::INDEX_BITS-1:0]     in_column,
  input  logic [etf_pkg::INDEX_BITS-1:0]     in_row,
  input  etf_pkg::etf_cfg_t                  cfg,
  input  etf_pkg::etf_cmd_t                  cmd,
  output etf_pkg::etf_status_t               status,
  output logic [etf_pkg::COUNT_BITS-1:0]     escape_count
);
  import etf_pkg::*;

  logic [PC_BITS-1:0]          pcx_r, pcy_r;
  logic signed [VAL_BITS-1:0]  cx_r, cy_r, x_r, y_r;
  logic signed [PROD_BITS-1:0] xx_r, yy_r, xy_r;
  logic [COUNT_BITS-1:0]       n_r, res_r, out_r;

  logic signed [SAT_BITS-1:0]  cx_sum, cy_sum, x_sum, y_sum;
  logic signed [SQ_BITS-1:0]   x2, y2;
  logic signed [XY_BITS-1:0]   xy2;
  logic signed [SUM_BITS-1:0]  mag;
  logic [COUNT_BITS-1:0]       n_inc;

  // c = edge + index * step, formed wide and then clamped.
  assign cx_sum = SAT_BITS'(cfg.x_min) + $signed(SAT_BITS'(pcx_r));
  assign cy_sum = SAT_BITS'(cfg.y_min) + $signed(SAT_BITS'(pcy_r));

  // Floor shifts of the products are arithmetic part-selects.
  assign x2  = $signed(xx_r[PROD_BITS-1:FRAC_BITS]);
  assign y2  = $signed(yy_r[PROD_BITS-1:FRAC_BITS]);
  assign xy2 = $signed(xy_r[PROD_BITS-1:FRAC_BITS-1]);

  assign mag   = SUM_BITS'(x2) + SUM_BITS'(y2);
  assign x_sum = SAT_BITS'(x2) - SAT_BITS'(y2) + SAT_BITS'(cx_r);
  assign y_sum = SAT_BITS'(xy2) + SAT_BITS'(cy_r);
  assign n_inc = n_r + COUNT_BITS'(1);

  assign status.escape     = (mag > LIMIT);
  assign status.last_round = (n_inc == cfg.max_iterations);
  assign status.max_zero   = (cfg.max_iterations == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pcx_r <= PC_BITS'(in_column) * PC_BITS'(cfg.x_step);
      pcy_r <= PC_BITS'(in_row) * PC_BITS'(cfg.y_step);
    end
    if (cmd.calc_c) begin
      cx_r <= sat_val(cx_sum);
      cy_r <= sat_val(cy_sum);
      x_r  <= sat_val(cx_sum);
      y_r  <= sat_val(cy_sum);
      n_r  <= '0;
    end else if (cmd.step) begin
      x_r <= sat_val(x_sum);
      y_r <= sat_val(y_sum);
      n_r <= n_inc;
    end
    if (cmd.mul) begin
      xx_r <= PROD_BITS'(x_r) * PROD_BITS'(x_r);
      yy_r <= PROD_BITS'(y_r) * PROD_BITS'(y_r);
      xy_r <= PROD_BITS'(x_r) * PROD_BITS'(y_r);
    end
    if (cmd.res_load) begin
      res_r <= cmd.res_hit ? n_r : '0;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign escape_count = out_r;

`ifndef SYNTHESIS
  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (n_r == $past(n_inc)))
    else $error("round counter did not advance by one");
  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load && cmd.res_hit) |=> (res_r == $past(n_r)))
    else $error("escape result does not match round");
`endif

endmodule

// File: hw/rtl/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel block.
// Depends on etf_pkg, etf_cfg_regs, etf_ctrl and etf_datapath.
//
// Usage: software writes the image edges, the per-pixel steps and the round
// limit through the cfg_ write port (index 0..4) while the block is idle.
// Each transfer on the in_ stream carries one pixel's column and row; each
// transfer on the out_ stream carries that pixel's escape count, in order.
//
// Steps: capture the pixel and form index * step, then form and clamp c,
// then run the iteration rounds, each of which registers the squares and
// cross product and then tests |z|^2 and updates z, and last move the
// result into the output register.
//
// The block works on one pixel at a time. A finished count waits in the
// output register while the next pixel is taken and computed; if the
// receiver still stalls when that one finishes, the block holds it and
// accepts nothing more until the output register frees. Reset restores the
// register defaults and empties both the state machine and the output.
module escape_time_fractal_pixel (
  input  logic                                clk,
  input  logic                                rst_n,
  // Pixel input stream. tdata: column [11:0], row [23:12].
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [etf_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // Result stream. tdata: escape_count [15:0].
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [etf_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [etf_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
  input  logic [etf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import etf_pkg::*;

  etf_cfg_t              cfg;
  etf_cmd_t              cmd;
  etf_status_t           status;
  logic [COUNT_BITS-1:0] escape_count;

  // Register file; the user must write it only between pixels, the block does not enforce this.
  etf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer: owns both handshakes and the output valid flag.
  etf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Arithmetic; the pixel fields are unpacked straight from tdata.
  etf_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_column    (in_tdata[INDEX_BITS-1:0]),
    .in_row       (in_tdata[2*INDEX_BITS-1:INDEX_BITS]),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .escape_count (escape_count)
  );

  assign out_tdata = OUT_DATA_BITS'(escape_count);

endmodule

// File: tb/tb_escape_time_fractal_pixel.sv
// Self-checking testbench for escape_time_fractal_pixel: pixel transfers go in,
// escape counts come out and are compared against an in-bench fixed-point model.
// Depends on etf_pkg and the escape_time_fractal_pixel RTL only.
module tb_escape_time_fractal_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  import etf_pkg::*;

  // An index the register file does not decode; writes to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  // Clamp bounds of the Q4.28 value range, held at 64 bits for the model.
  localparam longint VAL_HI = 2147483647;
  localparam longint VAL_LO = -VAL_HI - 1;

  // The slowest legal pixel runs 65535 rounds with no transfer on either stream,
  // and the limit allows several times that pixel's length.
  localparam int STALL_LIMIT = 600000;

  // Cycles to let pass after the last result before touching the registers.
  localparam int SETTLE_CYCLES = 8;

  // Random part: views of the plane, each with its own register setting.
  localparam int RANDOM_VIEWS   = 11;
  localparam int ITEMS_PER_VIEW = 24;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_DATA_BITS-1:0]   in_tdata  = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic                      cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_addr  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  // Shadow of the block's registers, kept in step with every write.
  etf_cfg_t view_cfg;

  // Escape counts predicted for accepted pixels, oldest first.
  logic [COUNT_BITS-1:0] escape_counts_due[$];

  int fault_count      = 0;
  int pixels_sent      = 0;
  int results_seen     = 0;
  int nonzero_counts   = 0;
  int views_programmed = 0;
  int idle_cycles      = 0;

  // Largest per-transfer wait of the sender and of the receiver.
  int in_gap_max  = 16;
  int out_gap_max = 16;

  // A long receiver hold, loaded by a test and counted down by the receiver.
  int rx_hold_len = 0;

  escape_time_fractal_pixel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // column [11:0], row [23:12]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // escape_count [15:0]
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point model of one pixel.
  // ---------------------------------------------------------------------------

  function automatic longint clamp_val(input longint v);
    if (v > VAL_HI) begin
      return VAL_HI;
    end
    if (v < VAL_LO) begin
      return VAL_LO;
    end
    return v;
  endfunction

  // Forms c from the pixel indexes and the current view, then runs z = z*z + c
  // from z = c. Squares are floored by FRAC_BITS, the cross product by one bit
  // less (which folds in the factor of two). The first round whose |z|^2 is
  // strictly above 4 is the count; a point that never gets there counts 0, and
  // so does a point that is already outside before the first update.
  function automatic logic [COUNT_BITS-1:0] escape_round(input logic [INDEX_BITS-1:0] col,
                                                         input logic [INDEX_BITS-1:0] row);
    longint cx, cy, x, y, x2, y2, xy2, limit;
    logic [COUNT_BITS-1:0] rounds;
    rounds = '0;
    limit  = longint'(4) <<< FRAC_BITS;
    cx = clamp_val(longint'($signed(view_cfg.x_min)) + longint'(col) * longint'(view_cfg.x_step));
    cy = clamp_val(longint'($signed(view_cfg.y_min)) + longint'(row) * longint'(view_cfg.y_step));
    x = cx;
    y = cy;
    for (int n = 0; n < int'(view_cfg.max_iterations); n++) begin
      x2 = (x * x) >>> FRAC_BITS;
      y2 = (y * y) >>> FRAC_BITS;
      if (x2 + y2 > limit) begin
        rounds = COUNT_BITS'(n);
        break;
      end
      xy2 = (x * y) >>> (FRAC_BITS - 1);
      // y is updated from the old x, so both products are taken first.
      y = clamp_val(xy2 + cy);
      x = clamp_val(x2 - y2 + cx);
    end
    return rounds;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes. Only issued while no pixel is in flight.
  // ---------------------------------------------------------------------------

  // One write per clock; cfg_we is left high so back-to-back writes never lower
  // and raise it within one time step. The caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] addr, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_X_MIN:    view_cfg.x_min          = data;
      REG_Y_MIN:    view_cfg.y_min          = data;
      REG_X_STEP:   view_cfg.x_step         = data[STEP_BITS-1:0];
      REG_Y_STEP:   view_cfg.y_step         = data[STEP_BITS-1:0];
      REG_MAX_ITER: view_cfg.max_iterations = data[COUNT_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Writes all five registers. The words may carry bits above a register's
  // width; the block is expected to drop them.
  task automatic program_view(input logic [31:0] xmin_w, input logic [31:0] ymin_w,
                              input logic [31:0] xstep_w, input logic [31:0] ystep_w,
                              input logic [31:0] iter_w);
    write_reg(REG_X_MIN, xmin_w);
    write_reg(REG_Y_MIN, ymin_w);
    write_reg(REG_X_STEP, xstep_w);
    write_reg(REG_Y_STEP, ystep_w);
    write_reg(REG_MAX_ITER, iter_w);
    cfg_we <= 1'b0;
    views_programmed++;
  endtask

  // ---------------------------------------------------------------------------
  // Pixel sender and end-of-phase wait.
  // ---------------------------------------------------------------------------

  // Offers one pixel after a random gap and returns at the edge of its transfer.
  // in_tvalid stays high on return, so the next call (or drain_results) must run
  // in the same time step; a zero gap then keeps it high with the new data.
  task automatic send_pixel(input logic [INDEX_BITS-1:0] col, input logic [INDEX_BITS-1:0] row);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row, col};
    do @(posedge clk); while (in_tready !== 1'b1);
    escape_counts_due.push_back(escape_round(col, row));
    pixels_sent++;
  endtask

  // Stops offering pixels and waits for every outstanding count. Each pixel
  // yields exactly one result, so an empty queue means the block is idle and its
  // last count has been taken; the settle wait follows.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (escape_counts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Register defaults straight out of reset: the plane from (-2,-2) in steps of
  // 1/256 with 2048 rounds. Covers a corner that is outside at once, the origin
  // (never escapes), c = -2 where |z|^2 sits exactly on 4 for good, a point
  // inside the main body, two points that escape after a few rounds, and the
  // far corner whose c clamps to the top of the value range.
  task automatic test_default_view();
    in_gap_max  = 16;
    out_gap_max = 16;
    send_pixel(12'd0,    12'd0);
    send_pixel(12'd512,  12'd512);
    send_pixel(12'd0,    12'd512);
    send_pixel(12'd448,  12'd512);
    send_pixel(12'd600,  12'd512);
    send_pixel(12'd256,  12'd768);
    send_pixel(12'd4095, 12'd4095);
    drain_results();
  endtask

  // Register and index extremes. With the most negative left edge, the most
  // positive bottom edge and the largest steps, every corner pixel clamps c to
  // one end of the range. Then the zero steps at the origin with the largest
  // round limit give the longest pixel the block can take. A write to an index
  // that decodes to nothing follows the first setting and must leave the view alone.
  task automatic test_range_extremes();
    program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    @(posedge clk);
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    send_pixel(12'd0,    12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0,    12'd4095);
    send_pixel(12'd4095, 12'd4095);
    drain_results();
    program_view(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_FFFF);
    send_pixel(12'd4095, 12'd4095);
    drain_results();
  endtask

  // Round limits of zero, one and two. With c = 1.5 the point is inside at
  // round zero and outside at round one, so only a limit of two reports it.
  task automatic test_zero_rounds();
    // Left edge -0.5, steps 1/256: column 512 lands on 1.5.
    program_view(32'hF800_0000, 32'h0000_0000, 32'h0010_0000, 32'h0010_0000, 32'd0);
    send_pixel(12'd0,    12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd512,  12'd0);
    drain_results();
    program_view(32'hF800_0000, 32'h0000_0000, 32'h0010_0000, 32'h0010_0000, 32'd1);
    send_pixel(12'd512, 12'd0);
    drain_results();
    program_view(32'hF800_0000, 32'h0000_0000, 32'h0010_0000, 32'h0010_0000, 32'd2);
    send_pixel(12'd512, 12'd0);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // back-to-back pixels. One count parks in the output register, the next one
  // finishes behind it, and from then on the input has to stall.
  task automatic test_output_backpressure();
    program_view(32'hF000_0000, 32'hF000_0000, 32'h0002_0000, 32'h0002_0000, 32'd6);
    in_gap_max  = 0;
    out_gap_max = 0;
    rx_hold_len = 600;
    for (int i = 0; i < 8; i++) begin
      send_pixel(INDEX_BITS'($urandom_range(0, 4095)), INDEX_BITS'($urandom_range(0, 4095)));
    end
    drain_results();
  endtask

  // Random views. Most are windows onto the set's neighborhood (left edge in
  // [-2.5,-0.5], bottom edge in [-2,0], spans up to 4) with modest round limits
  // so that the counts spread out. Every fourth view takes arbitrary edge and
  // step words and round limits up to 40, and one view runs deep round limits.
  // Pacing changes per view; some views run with no gaps on one side or both.
  task automatic test_random_views();
    logic [31:0] xmin_w, ymin_w, xstep_w, ystep_w, iter_w;
    for (int v = 0; v < RANDOM_VIEWS; v++) begin
      if (v % 4 == 3) begin
        xmin_w  = $urandom;
        ymin_w  = $urandom;
        xstep_w = $urandom;
        ystep_w = $urandom;
        iter_w  = {16'($urandom), 16'($urandom_range(0, 40))};
      end else begin
        xmin_w  = $urandom_range(0, 32'h2000_0000) - 32'd671088640;
        ymin_w  = $urandom_range(0, 32'h2000_0000) - 32'h2000_0000;
        xstep_w = {1'($urandom), 31'($urandom_range(32'h0000_4000, 32'h0004_0000))};
        ystep_w = {1'($urandom), 31'($urandom_range(32'h0000_4000, 32'h0004_0000))};
        if (v == 5) begin
          iter_w = {16'($urandom), 16'($urandom_range(1024, 2048))};
        end else begin
          iter_w = {16'($urandom), 16'($urandom_range(1, 200))};
        end
      end
      program_view(xmin_w, ymin_w, xstep_w, ystep_w, iter_w);
      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 16;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      for (int i = 0; i < ITEMS_PER_VIEW; i++) begin
        send_pixel(INDEX_BITS'($urandom_range(0, 4095)), INDEX_BITS'($urandom_range(0, 4095)));
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker. Draws a wait before each transfer and honors a
  // long hold when a test loads one. out_tready gets one assignment per edge.
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int stall_left;
    logic [COUNT_BITS-1:0] want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        if (escape_counts_due.size() == 0) begin
          $error("escape_count: result %0d arrived with no pixel outstanding",
                 out_tdata[COUNT_BITS-1:0]);
          fault_count++;
        end else begin
          want = escape_counts_due.pop_front();
          if (out_tdata[COUNT_BITS-1:0] !== want) begin
            $error("escape_count: expected %0d, actual %0d", want, out_tdata[COUNT_BITS-1:0]);
            fault_count++;
          end
          if (want != 0) begin
            nonzero_counts++;
          end
        end
        stall_left = $urandom_range(0, out_gap_max);
      end
      if (rx_hold_len > 0) begin
        rx_hold_len--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run of cycles with no transfer on either stream ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("escape_time_fractal_pixel: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    view_cfg = '{x_min: X_MIN_RST, y_min: Y_MIN_RST, x_step: X_STEP_RST,
                 y_step: Y_STEP_RST, max_iterations: MAX_ITER_RST};
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_default_view();
    test_range_extremes();
    test_zero_rounds();
    test_output_backpressure();
    test_random_views();

    // Anything arriving now has no pixel behind it and fails in the checker.
    drain_results();
    repeat (64) @(posedge clk);

    $display("Sent %0d pixels under %0d register settings and checked %0d counts,",
             pixels_sent, views_programmed, results_seen);
    $display("%0d of them nonzero, with random pacing and one long output hold.",
             nonzero_counts);
    if (fault_count == 0) begin
      $display("escape_time_fractal_pixel: match");
    end else begin
      $display("escape_time_fractal_pixel: mismatch");
    end
    $finish;
  end

endmodule
